// ===== src/owm_pkg.sv =====
// Package for the one-wire bus master: types, register map, phase codes and timing constants.
// Used by the top level, owm_cfg_regs and owm_engine; depends on nothing.
package owm_pkg;

    // Width of the phase timer and the fixed release time ahead of a reset pulse.
    localparam int TIMER_BITS   = 10;
    localparam int PRE_RESET_US = 50;

    // Configuration register file.
    localparam int CFG_W     = 10;
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = $clog2(NUM_CFG);
    localparam int APB_AW    = CFG_IDX_W + 2;
    localparam int APB_DW    = 32;

    typedef logic [CFG_W-1:0] cfg_word_t;
    typedef cfg_word_t [NUM_CFG-1:0] cfg_bank_t;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_DELAY = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_START     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_HOLD     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_BIT_GAP        = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE    = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL      = CFG_IDX_W'(7);

    // Reset values, highest register first.
    localparam cfg_bank_t CFG_RESET_VALUES = {
        10'd65, 10'd5, 10'd2, 10'd65, 10'd5, 10'd500, 10'd40, 10'd500
    };

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_RPRE    = 4'd1,
        PH_RLOW    = 4'd2,
        PH_RREL    = 4'd3,
        PH_RWATCH  = 4'd4,
        PH_RREC    = 4'd5,
        PH_WSTART  = 4'd6,
        PH_WHOLD   = 4'd7,
        PH_WGAP    = 4'd8,
        PH_RDPRE   = 4'd9,
        PH_RDSTART = 4'd10,
        PH_RDSAMP  = 4'd11,
        PH_RDTAIL  = 4'd12
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       line_level;
    } owm_item_t;

    typedef struct packed {
        logic       presence;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } owm_result_t;

    // Loads a phase duration: masked to the timer width, zero counts as one microsecond.
    function automatic logic [TIMER_BITS-1:0] phase_time(input cfg_word_t d);
        logic [TIMER_BITS-1:0] t;
        t = TIMER_BITS'(d);
        if (t == '0) begin
            t = TIMER_BITS'(1);
        end
        return t;
    endfunction

endpackage

// ===== src/one_wire_bus_master.sv =====
// Top level of the one-wire bus master: input register, phase sequencer, result register.
// Depends on owm_pkg, owm_cfg_regs and owm_engine.
//
// Usage: every request on the s_ channel is either a one-microsecond tick or a command
// (bus reset with presence detect, write byte, read byte), selected by s_tuser. The
// caller sends one tick per microsecond together with the sampled line level, and the
// block returns exactly one result per request on the m_ channel. That result tells
// whether to pull the open-drain line low for the next microsecond, plus busy, done,
// the last read byte and the presence flag of the last bus reset. Commands that arrive
// while a command is still running are dropped and do not count as ticks.
// Timing of the bus phases comes from eight 10-bit registers on the APB-style port,
// at byte addresses 0, 4, ... 28; they should be written only while the block is idle.
// A request accepted into the input register is processed into the result register when
// that register is empty or being emptied, and its result then shows on m_tvalid.
// Throughput: one request per cycle while m_tready is high; the whole phase update is a
// single pass through the timer decrement and phase selection between the two registers.
// Stall: while m_tready is low the result holds, one more request can still be taken
// into the input register, and then s_tready drops until the result is taken.
// Reset (aresetn low, synchronous): both registers empty, the sequencer idle with
// presence and read byte cleared, and the timing registers back at their defaults.
module one_wire_bus_master
    import owm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Request channel.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [7:0] data_byte, [8] line_level, rest zero
    input  logic [1:0]        s_tuser,   // [1:0] kind
    // Result channel.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                         // [10:3] read_byte, [11] presence, rest zero
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic        in_valid_reg, in_valid_next;
    owm_item_t   in_item_reg, in_item_next;
    logic        out_valid_reg, out_valid_next;
    owm_result_t out_res_reg, out_res_next;
    owm_result_t result;
    cfg_bank_t   cfg;
    logic        advance;
    logic        fire;
    logic        take;

    owm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // The result register can take a new result when it is empty or being emptied.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg;
        if (take) begin
            in_item_next  = '{kind: kind_t'(s_tuser), data_byte: s_tdata[7:0],
                              line_level: s_tdata[8]};
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_res_next   = result;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg};

endmodule

// ===== src/owm_cfg_regs.sv =====
// Configuration register file of the one-wire bus master behind an APB-style port.
// Depends on owm_pkg.
module owm_cfg_regs
    import owm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_bank_t         cfg
);

    cfg_bank_t              cfg_reg;
    logic [CFG_IDX_W-1:0]   idx;

    assign idx    = paddr[APB_AW-1:2];
    assign pready = 1'b1;
    assign prdata = APB_DW'(cfg_reg[idx]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET_VALUES;
        end else if (psel && penable && pwrite && pready) begin
            cfg_reg[idx] <= pwdata[CFG_W-1:0];
        end
    end

endmodule

// ===== src/owm_engine.sv =====
// Phase sequencer of the one-wire bus master: phase, timer, bit count and shift register.
// Processes one registered item per fire cycle; depends on owm_pkg.
module owm_engine
    import owm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  owm_item_t   item,
    input  cfg_bank_t   cfg,
    output owm_result_t result
);

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] time_reg, time_next;
    logic [2:0]            bits_reg, bits_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  presence_reg, presence_next;
    logic [7:0]            last_read_reg, last_read_next;
    logic                  done;

    // Next state.
    always_comb begin
        phase_next     = phase_reg;
        time_next      = time_reg;
        bits_next      = bits_reg;
        shift_next     = shift_reg;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;
        if (fire) begin
            if (item.kind == KIND_TICK) begin
                if (phase_reg == PH_IDLE) begin
                    phase_next = PH_IDLE;
                end else if (phase_reg == PH_RWATCH && !item.line_level) begin
                    presence_next = 1'b1;
                    phase_next    = PH_RREC;
                    time_next     = phase_time(cfg[REG_RECOVERY]);
                end else if (time_reg > TIMER_BITS'(1)) begin
                    time_next = time_reg - TIMER_BITS'(1);
                end else begin
                    case (phase_reg)
                        PH_RPRE: begin
                            phase_next = PH_RLOW;
                            time_next  = phase_time(cfg[REG_RESET_LOW]);
                        end
                        PH_RLOW: begin
                            phase_next = PH_RREL;
                            time_next  = phase_time(cfg[REG_PRESENCE_DELAY]);
                        end
                        PH_RREL: begin
                            phase_next = PH_RWATCH;
                            time_next  = phase_time(cfg[REG_RECOVERY]);
                        end
                        PH_WSTART: begin
                            phase_next = PH_WHOLD;
                            time_next  = phase_time(cfg[REG_WRITE_HOLD]);
                        end
                        PH_WHOLD: begin
                            phase_next = PH_WGAP;
                            time_next  = phase_time(cfg[REG_BIT_GAP]);
                        end
                        PH_WGAP: begin
                            shift_next = {1'b0, shift_reg[7:1]};
                            if (bits_reg == 3'd0) begin
                                phase_next = PH_IDLE;
                                time_next  = '0;
                                done       = 1'b1;
                            end else begin
                                bits_next  = bits_reg - 3'd1;
                                phase_next = PH_WSTART;
                                time_next  = phase_time(cfg[REG_SLOT_START]);
                            end
                        end
                        PH_RDPRE: begin
                            phase_next = PH_RDSTART;
                            time_next  = phase_time(cfg[REG_SLOT_START]);
                        end
                        PH_RDSTART: begin
                            phase_next = PH_RDSAMP;
                            time_next  = phase_time(cfg[REG_READ_SAMPLE]);
                        end
                        PH_RDSAMP: begin
                            shift_next = {item.line_level, shift_reg[7:1]};
                            phase_next = PH_RDTAIL;
                            time_next  = phase_time(cfg[REG_READ_TAIL]);
                        end
                        PH_RDTAIL: begin
                            if (bits_reg == 3'd0) begin
                                last_read_next = shift_reg;
                                phase_next     = PH_IDLE;
                                time_next      = '0;
                                done           = 1'b1;
                            end else begin
                                bits_next  = bits_reg - 3'd1;
                                phase_next = PH_RDSTART;
                                time_next  = phase_time(cfg[REG_SLOT_START]);
                            end
                        end
                        default: begin
                            // Watch window or recovery ran out.
                            phase_next = PH_IDLE;
                            time_next  = '0;
                            done       = 1'b1;
                        end
                    endcase
                end
            end else if (phase_reg == PH_IDLE) begin
                bits_next = 3'd7;
                case (item.kind)
                    KIND_RESET: begin
                        presence_next = 1'b0;
                        phase_next    = PH_RPRE;
                        time_next     = phase_time(CFG_W'(PRE_RESET_US));
                    end
                    KIND_WRITE: begin
                        shift_next = item.data_byte;
                        phase_next = PH_WSTART;
                        time_next  = phase_time(cfg[REG_SLOT_START]);
                    end
                    default: begin
                        shift_next = 8'd0;
                        phase_next = PH_RDPRE;
                        time_next  = phase_time(cfg[REG_SLOT_START]);
                    end
                endcase
            end
        end
    end

    // Outputs, taken from the state after the item.
    always_comb begin
        case (phase_next)
            PH_RLOW, PH_WSTART, PH_RDSTART: result.drive_low = 1'b1;
            PH_WHOLD:                       result.drive_low = ~shift_next[0];
            default:                        result.drive_low = 1'b0;
        endcase
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = done;
        result.read_byte = last_read_next;
        result.presence  = presence_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            time_reg      <= '0;
            bits_reg      <= '0;
            shift_reg     <= '0;
            presence_reg  <= 1'b0;
            last_read_reg <= '0;
        end else begin
            phase_reg     <= phase_next;
            time_reg      <= time_next;
            bits_reg      <= bits_next;
            shift_reg     <= shift_next;
            presence_reg  <= presence_next;
            last_read_reg <= last_read_next;
        end
    end

endmodule

// ===== src/owm_checker.sv =====
// Port-level checker for the one-wire bus master, bound to the top level.
// Depends on one_wire_bus_master.
module owm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pready
);

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // A completing request already reports the block idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1])
        else $error("done reported while busy");

    // The line is only pulled low while a command runs.
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("line driven while idle");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable |-> pready)
        else $error("configuration access stalled");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (.*);
